FILE: hw/rtl/geofence_guided_roll_command_assert.svh
// Assertion macros for the geofence roll command block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GEOFENCE_GUIDED_ROLL_COMMAND_ASSERT_SVH
`define GEOFENCE_GUIDED_ROLL_COMMAND_ASSERT_SVH

// same-cycle implication
`define GFRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gfrc: same-cycle check failed");

// next-cycle implication
`define GFRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gfrc: next-cycle check failed");

`endif

FILE: hw/rtl/gfrc_pkg.sv
// Package for the geofence roll command block: word types, register
// indexes, zone codes, gains and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package gfrc_pkg;

	localparam int POS_W   = 20;
	localparam int VEL_W   = 16;
	localparam int ANG_W   = 16;
	localparam int DIST_W  = 23;
	localparam int OFS_W   = 25;
	localparam int ANGLE_W = 32;

	localparam logic [2:0] REG_FENCE_MIN_X  = 3'd0;
	localparam logic [2:0] REG_FENCE_MIN_Y  = 3'd1;
	localparam logic [2:0] REG_FENCE_WIDTH  = 3'd2;
	localparam logic [2:0] REG_FENCE_HEIGHT = 3'd3;
	localparam logic [2:0] REG_ROLL_LIMIT   = 3'd4;

	localparam logic [1:0] ZONE_CENTER   = 2'd0;
	localparam logic [1:0] ZONE_BLEND    = 2'd1;
	localparam logic [1:0] ZONE_GOAL     = 2'd2;
	localparam logic [1:0] ZONE_GOAL_OUT = 2'd3;

	// gain * 10
	localparam logic [5:0] GAIN_CENTER = 6'd50;
	localparam logic [5:0] GAIN_BLEND  = 6'd35;
	localparam logic [5:0] GAIN_GOAL   = 6'd30;

	localparam logic [15:0] SPEED_MIN = 16'd256;
	localparam logic [15:0] SPEED_REF = 16'd2560;

	localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

	localparam logic [ANGLE_W-1:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [ANG_W-1:0]        heading;
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] roll_command;
		logic [1:0]         zone;
	} command_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [POS_W-1:0]  gx;
		logic signed [POS_W-1:0]  gy;
		logic [ANG_W-1:0]         head;
		logic signed [DIST_W-1:0] d;
		logic                     la_in;
		logic                     g_in;
	} ctx_a_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] gx;
		logic signed [POS_W-1:0] gy;
		logic [ANG_W-1:0]        head;
		logic [1:0]              zone;
		logic [15:0]             spd;
		logic                    neg_x;
	} ctx_b_t;

	typedef struct packed {
		logic [ANG_W-1:0] head;
		logic [1:0]       zone;
		logic [15:0]      spd;
	} ctx_d_t;

endpackage

FILE: hw/rtl/gfrc_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Carries a sideband tag; no package dependency.
`timescale 1ns / 1ps

module gfrc_div #(
	parameter int NW = 40,
	parameter int DW = 18,
	parameter int QW = 22,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] out_tag
);

	localparam int W = NW + DW + QW;

	logic          v_s   [QW];
	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int B = QW - 1 - k;
		logic          pv;
		logic [NW-1:0] prem;
		logic [DW-1:0] pden;
		logic [QW-1:0] pquo;
		logic [TW-1:0] ptag;
		logic [W-1:0]  dsh;
		logic          take;

		if (k == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = num;
			assign pden = den;
			assign pquo = '0;
			assign ptag = tag;
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign prem = rem_s[k-1];
			assign pden = den_s[k-1];
			assign pquo = quo_s[k-1];
			assign ptag = tag_s[k-1];
		end

		assign dsh  = W'(pden) << B;
		assign take = W'(prem) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NW'(W'(prem) - dsh) : prem;
				den_s[k] <= pden;
				quo_s[k] <= pquo | (take ? (QW'(1) << B) : '0);
				tag_s[k] <= ptag;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_tag   = tag_s[QW-1];

endmodule

FILE: hw/rtl/gfrc_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in 1/2^32 turn.
// Uses gfrc_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module gfrc_cordic import gfrc_pkg::*; #(
	parameter int STAGES = 16,
	parameter int TW     = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [OFS_W-1:0] x,
	input  logic signed [OFS_W-1:0] y,
	input  logic [TW-1:0]           tag,
	output logic                    out_valid,
	output logic [ANGLE_W-1:0]      angle,
	output logic [TW-1:0]           out_tag
);

	localparam int CW = OFS_W + 11;

	logic                 v_s [STAGES+1];
	logic signed [CW-1:0] x_s [STAGES+1];
	logic signed [CW-1:0] y_s [STAGES+1];
	logic [ANGLE_W-1:0]   a_s [STAGES+1];
	logic                 z_s [STAGES+1];
	logic [TW-1:0]        t_s [STAGES+1];

	logic signed [CW-1:0] xw, yw;
	assign xw = CW'(x) <<< 8;
	assign yw = CW'(y) <<< 8;

	// fold left half-plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= (x < 0) ? -xw : xw;
			y_s[0] <= (x < 0) ? -yw : yw;
			a_s[0] <= (x < 0) ? HALF_TURN : '0;
			z_s[0] <= (x == 0) && (y == 0);
			t_s[0] <= tag;
		end
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_rot
		logic signed [CW-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k] > 0) begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					a_s[k+1] <= a_s[k] + ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					a_s[k+1] <= a_s[k] - ATAN_TAB[k];
				end
				z_s[k+1] <= z_s[k];
				t_s[k+1] <= t_s[k];
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign angle     = z_s[STAGES] ? '0 : a_s[STAGES];
	assign out_tag   = t_s[STAGES];

endmodule

FILE: hw/rtl/geofence_guided_roll_command.sv
// Geofence-guided roll command: one roll target and zone per sample word.
// Fully pipelined: a new sample word every cycle unless the output stalls. It passes
// through the squares, a 16-stage square root, a 22-stage blend divider, the
// CORDIC, a 19-stage gain divider and the output register. A stalled output
// word freezes the whole pipeline. Uses gfrc_pkg, gfrc_div, gfrc_cordic.
`timescale 1ns / 1ps
`include "geofence_guided_roll_command_assert.svh"

module geofence_guided_roll_command import gfrc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        command_valid,
	input  logic        command_ready,
	output command_t    command,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int SQ_STEPS = 16;

	// configuration
	logic signed [19:0] fence_min_x_q, fence_min_y_q;
	logic [18:0]        fence_width_q, fence_height_q;
	logic [14:0]        roll_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fence_min_x_q  <= '0;
			fence_min_y_q  <= '0;
			fence_width_q  <= 19'd16000;
			fence_height_q <= 19'd16000;
			roll_limit_q   <= 15'd5461;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FENCE_MIN_X:  fence_min_x_q  <= cfg_data;
				REG_FENCE_MIN_Y:  fence_min_y_q  <= cfg_data;
				REG_FENCE_WIDTH:  fence_width_q  <= cfg_data[18:0];
				REG_FENCE_HEIGHT: fence_height_q <= cfg_data[18:0];
				REG_ROLL_LIMIT:   roll_limit_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic signed [20:0] fence_max_x, fence_max_y;
	logic signed [21:0] cen_x, cen_y;
	assign fence_max_x = 21'(fence_min_x_q) + $signed({2'b00, fence_width_q});
	assign fence_max_y = 21'(fence_min_y_q) + $signed({2'b00, fence_height_q});
	assign cen_x = (22'(fence_min_x_q) <<< 1) + $signed({3'b000, fence_width_q});
	assign cen_y = (22'(fence_min_y_q) <<< 1) + $signed({3'b000, fence_height_q});

	logic adv;
	assign adv          = !command_valid || command_ready;
	assign sample_ready = adv;

	// s1: squares
	logic        v_s1;
	sample_t     smp_s1;
	logic [30:0] vx2_s1, vy2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1 <= sample;
			vx2_s1 <= 31'(32'(sample.vel_x) * 32'(sample.vel_x));
			vy2_s1 <= 31'(32'(sample.vel_y) * 32'(sample.vel_y));
		end
	end

	// s2: boundary distance, lookahead and goal membership
	logic signed [DIST_W-1:0] dx0, dx1, dy0, dy1, dmx, dmy, dmin;
	logic signed [25:0]       lax, lay;
	logic                     la_in, g_in;

	always_comb begin
		dx0  = DIST_W'(smp_s1.pos_x) - DIST_W'(fence_min_x_q);
		dx1  = DIST_W'(fence_max_x) - DIST_W'(smp_s1.pos_x);
		dy0  = DIST_W'(smp_s1.pos_y) - DIST_W'(fence_min_y_q);
		dy1  = DIST_W'(fence_max_y) - DIST_W'(smp_s1.pos_y);
		dmx  = (dx1 < dx0) ? dx1 : dx0;
		dmy  = (dy1 < dy0) ? dy1 : dy0;
		dmin = (dmy < dmx) ? dmy : dmx;
		lax  = (26'(smp_s1.pos_x) <<< 5) + 26'(smp_s1.vel_x) + (26'(smp_s1.vel_x) <<< 1);
		lay  = (26'(smp_s1.pos_y) <<< 5) + 26'(smp_s1.vel_y) + (26'(smp_s1.vel_y) <<< 1);
		la_in = (lax >= (26'(fence_min_x_q) <<< 5)) && (lax < (26'(fence_max_x) <<< 5)) &&
			(lay >= (26'(fence_min_y_q) <<< 5)) && (lay < (26'(fence_max_y) <<< 5));
		g_in = (21'(smp_s1.goal_x) >= 21'(fence_min_x_q)) && (21'(smp_s1.goal_x) < fence_max_x) &&
			(21'(smp_s1.goal_y) >= 21'(fence_min_y_q)) && (21'(smp_s1.goal_y) < fence_max_y);
	end

	// square root, one result bit per stage; entry 0 is s2
	logic        sqrt_v_s    [SQ_STEPS+1];
	logic [31:0] sqrt_rem_s  [SQ_STEPS+1];
	logic [15:0] sqrt_root_s [SQ_STEPS+1];
	ctx_a_t      sqrt_ctx_s  [SQ_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_v_s[0] <= 1'b0;
		end else if (adv) begin
			sqrt_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqrt_rem_s[0]       <= 32'(vx2_s1) + 32'(vy2_s1);
			sqrt_root_s[0]      <= '0;
			sqrt_ctx_s[0].px    <= smp_s1.pos_x;
			sqrt_ctx_s[0].py    <= smp_s1.pos_y;
			sqrt_ctx_s[0].gx    <= smp_s1.goal_x;
			sqrt_ctx_s[0].gy    <= smp_s1.goal_y;
			sqrt_ctx_s[0].head  <= smp_s1.heading;
			sqrt_ctx_s[0].d     <= dmin;
			sqrt_ctx_s[0].la_in <= la_in;
			sqrt_ctx_s[0].g_in  <= g_in;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam int B = SQ_STEPS - 1 - k;
		logic [31:0] cand;
		logic        take;
		assign cand = (32'(sqrt_root_s[k]) << (B + 1)) | (32'd1 << (2 * B));
		assign take = sqrt_rem_s[k] >= cand;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqrt_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sqrt_v_s[k+1] <= sqrt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sqrt_rem_s[k+1]  <= take ? sqrt_rem_s[k] - cand : sqrt_rem_s[k];
				sqrt_root_s[k+1] <= sqrt_root_s[k] | (take ? (16'd1 << B) : 16'd0);
				sqrt_ctx_s[k+1]  <= sqrt_ctx_s[k];
			end
		end
	end

	// s3: zone select
	ctx_a_t             ca;
	logic [15:0]        spd;
	logic [17:0]        danger;
	logic signed [27:0] d32, dang_sx, warn_sx;
	logic [1:0]         zone;
	logic signed [22:0] dgx, dgy;

	always_comb begin
		ca      = sqrt_ctx_s[SQ_STEPS];
		spd     = (sqrt_root_s[SQ_STEPS] < SPEED_MIN) ? SPEED_MIN : sqrt_root_s[SQ_STEPS];
		danger  = 18'(spd) + (18'(spd) << 1);
		dang_sx = 28'(danger);
		warn_sx = 28'(danger) <<< 1;
		d32     = 28'(ca.d) <<< 5;
		if ((!ca.la_in && d32 < warn_sx) || d32 < dang_sx) begin
			zone = ZONE_CENTER;
		end else if (d32 < warn_sx) begin
			zone = ZONE_BLEND;
		end else if (ca.g_in) begin
			zone = ZONE_GOAL;
		end else begin
			zone = ZONE_GOAL_OUT;
		end
		dgx = (23'(ca.gx) <<< 1) - 23'(cen_x);
		dgy = (23'(ca.gy) <<< 1) - 23'(cen_y);
	end

	logic               v_s3;
	ctx_b_t             ctx_s3;
	logic [17:0]        num_s3, danger_s3;
	logic signed [22:0] dgx_s3, dgy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= sqrt_v_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3.px    <= ca.px;
			ctx_s3.py    <= ca.py;
			ctx_s3.gx    <= ca.gx;
			ctx_s3.gy    <= ca.gy;
			ctx_s3.head  <= ca.head;
			ctx_s3.zone  <= zone;
			ctx_s3.spd   <= spd;
			ctx_s3.neg_x <= dgx[22];
			num_s3       <= 18'(d32 - dang_sx);
			danger_s3    <= danger;
			dgx_s3       <= dgx;
			dgy_s3       <= dgy;
		end
	end

	// s4: blend numerators
	logic [21:0] adx, ady;
	assign adx = dgx_s3[22] ? 22'(-dgx_s3) : 22'(dgx_s3);
	assign ady = dgy_s3[22] ? 22'(-dgy_s3) : 22'(dgy_s3);

	logic        v_s4, neg_y_s4;
	ctx_b_t      ctx_s4;
	logic [39:0] prod_x_s4, prod_y_s4;
	logic [17:0] danger_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4    <= ctx_s3;
			neg_y_s4  <= dgy_s3[22];
			prod_x_s4 <= 40'(adx) * 40'(num_s3);
			prod_y_s4 <= 40'(ady) * 40'(num_s3);
			danger_s4 <= danger_s3;
		end
	end

	logic        bdx_v, bdy_v, bdy_neg;
	logic [21:0] qx, qy;
	ctx_b_t      bdx_ctx;

	gfrc_div #(.NW(40), .DW(18), .QW(22), .TW($bits(ctx_b_t))) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.num(prod_x_s4), .den(danger_s4), .tag(ctx_s4),
		.out_valid(bdx_v), .quo(qx), .out_tag(bdx_ctx)
	);

	gfrc_div #(.NW(40), .DW(18), .QW(22), .TW(1)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s4),
		.num(prod_y_s4), .den(danger_s4), .tag(neg_y_s4),
		.out_valid(bdy_v), .quo(qy), .out_tag(bdy_neg)
	);

	// s5: target point
	logic signed [23:0] sqx, sqy, tx, ty;

	always_comb begin
		sqx = bdx_ctx.neg_x ? -24'(qx) : 24'(qx);
		sqy = bdy_neg ? -24'(qy) : 24'(qy);
		case (bdx_ctx.zone)
			ZONE_BLEND: begin
				tx = 24'(cen_x) + sqx;
				ty = 24'(cen_y) + sqy;
			end
			ZONE_GOAL: begin
				tx = 24'(bdx_ctx.gx) <<< 1;
				ty = 24'(bdx_ctx.gy) <<< 1;
			end
			default: begin
				tx = 24'(cen_x);
				ty = 24'(cen_y);
			end
		endcase
	end

	logic               v_s5;
	logic signed [23:0] tx_s5, ty_s5;
	logic signed [19:0] px_s5, py_s5;
	ctx_d_t             ctx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= bdx_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_s5       <= tx;
			ty_s5       <= ty;
			px_s5       <= bdx_ctx.px;
			py_s5       <= bdx_ctx.py;
			ctx_s5.head <= bdx_ctx.head;
			ctx_s5.zone <= bdx_ctx.zone;
			ctx_s5.spd  <= bdx_ctx.spd;
		end
	end

	// s6: offset to target
	logic                    v_s6;
	logic signed [OFS_W-1:0] ox_s6, oy_s6;
	ctx_d_t                  ctx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ox_s6  <= OFS_W'(tx_s5) - (OFS_W'(px_s5) <<< 1);
			oy_s6  <= OFS_W'(ty_s5) - (OFS_W'(py_s5) <<< 1);
			ctx_s6 <= ctx_s5;
		end
	end

	logic               cor_v;
	logic [ANGLE_W-1:0] cor_ang;
	ctx_d_t             cor_ctx;

	gfrc_cordic #(.STAGES(CORDIC_STAGES), .TW($bits(ctx_d_t))) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s6),
		.x(ox_s6), .y(oy_s6), .tag(ctx_s6),
		.out_valid(cor_v), .angle(cor_ang), .out_tag(cor_ctx)
	);

	// s7: wrapped heading error
	logic [ANGLE_W-1:0] herr;
	assign herr = cor_ang - {cor_ctx.head, 16'h0000};

	logic               v_s7, neg_s7;
	logic [ANGLE_W-1:0] mag_s7;
	logic [5:0]         gain_s7;
	logic [15:0]        m_s7;
	logic [1:0]         zone_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= cor_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s7  <= herr > HALF_TURN;
			mag_s7  <= (herr > HALF_TURN) ? -herr : herr;
			m_s7    <= (cor_ctx.spd < SPEED_REF) ? SPEED_REF : cor_ctx.spd;
			zone_s7 <= cor_ctx.zone;
			case (cor_ctx.zone)
				ZONE_CENTER: gain_s7 <= GAIN_CENTER;
				ZONE_BLEND:  gain_s7 <= GAIN_BLEND;
				default:     gain_s7 <= GAIN_GOAL;
			endcase
		end
	end

	// s8: gain product and speed divisor
	logic        v_s8;
	logic [37:0] numf_s8;
	logic [22:0] denf_s8;
	logic [2:0]  tag_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			numf_s8 <= 38'(mag_s7) * 38'(gain_s7);
			denf_s8 <= 23'(m_s7) << 7;
			tag_s8  <= {neg_s7, zone_s7};
		end
	end

	logic        fdiv_v;
	logic [18:0] fq;
	logic [2:0]  ftag;

	gfrc_div #(.NW(38), .DW(23), .QW(19), .TW(3)) u_div_gain (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s8),
		.num(numf_s8), .den(denf_s8), .tag(tag_s8),
		.out_valid(fdiv_v), .quo(fq), .out_tag(ftag)
	);

	// output register with clamp
	logic [18:0] lim, cm;
	assign lim = 19'(roll_limit_q);
	assign cm  = (fq > lim) ? lim : fq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_valid <= 1'b0;
		end else if (adv) begin
			command_valid <= fdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			command.roll_command <= ftag[2] ? -16'(cm) : 16'(cm);
			command.zone         <= ftag[1:0];
		end
	end

	`GFRC_ASSERT_NOW(a_div_lock, 1'b1, bdx_v == bdy_v)
	`GFRC_ASSERT_NEXT(a_drain, command_valid && command_ready && !fdiv_v, !command_valid)
	`GFRC_ASSERT_NEXT(a_stall_keep, command_valid && !command_ready, command_valid)

endmodule
